@@ rtl/core/pgs_pkg.sv @@
// ----------------------------------------------------------------------------
// pgs_pkg
// Shared codes and an arithmetic helper for the Gauss-Seidel Poisson solver.
// ----------------------------------------------------------------------------
package pgs_pkg;

  // Item function codes
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_SOLVE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_INTERIOR = 2'd0;
  localparam logic [1:0] CFG_SPACING  = 2'd1;
  localparam logic [1:0] CFG_TOL      = 2'd2;
  localparam logic [1:0] CFG_SWEEPS   = 2'd3;

  // Configuration reset values
  localparam logic [3:0]  RST_INTERIOR = 4'd3;
  localparam logic [30:0] RST_SPACING  = 31'd65536;
  localparam logic [30:0] RST_TOL      = 31'd7;
  localparam logic [15:0] RST_SWEEPS   = 16'd1000;

  localparam logic [30:0] MAX_POS31 = 31'h7FFF_FFFF;

  // Signed 32-bit add, saturated on overflow
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

endpackage

@@ rtl/core/pgs_grid_ram.sv @@
// ----------------------------------------------------------------------------
// pgs_grid_ram
// Grid store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pgs_grid_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic signed [31:0]   wdata,
  input  logic [AW-1:0]        raddr,
  output logic signed [31:0]   rdata
);

  logic signed [31:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/poisson_gauss_seidel_solver_core.sv @@
// ----------------------------------------------------------------------------
// poisson_gauss_seidel_solver_core
// Five-point Gauss-Seidel Poisson relaxation over a grid held in one RAM.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------
//  in       | input     | in_valid/in_ready   | func, row, col, load_value
//  out      | output    | out_valid/out_ready | cell_value, sweep_count,
//           |           |                     | converged, max_change
//  cfg      | input     | cfg_we              | cfg_index, cfg_data
//
// After reset a clearing pass zeroes the RAM; no transaction is accepted
// meanwhile, configuration writes are taken. A load writes the RAM as it is
// accepted. In a solve each cell reads its four neighbours and its old value
// through the single RAM read port, adding the neighbours and the source
// term into one accumulator, then does one write.
// A held output stalls a read or solve at its end; loads continue while idle.
// ----------------------------------------------------------------------------
module poisson_gauss_seidel_solver_core #(
  parameter int GRID_SIDE = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [3:0]         row,
  input  logic [3:0]         col,
  input  logic signed [31:0] load_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] cell_value,
  output logic [15:0]        sweep_count,
  output logic               converged,
  output logic [30:0]        max_change
);

  localparam int DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(GRID_SIDE);
  localparam int NMAX  = GRID_SIDE - 2;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_SRC1  = 3'd3;
  localparam logic [2:0] S_SRC2  = 3'd4;
  localparam logic [2:0] S_CELL  = 3'd5;
  localparam logic [2:0] S_SWEND = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [2:0] PH_UP    = 3'd0;
  localparam logic [2:0] PH_DOWN  = 3'd1;
  localparam logic [2:0] PH_LEFT  = 3'd2;
  localparam logic [2:0] PH_RIGHT = 3'd3;
  localparam logic [2:0] PH_OLD   = 3'd4;
  localparam logic [2:0] PH_SRC   = 3'd5;
  localparam logic [2:0] PH_WRITE = 3'd6;

  // Configuration registers
  logic [3:0]  cfg_n;
  logic [30:0] cfg_h;
  logic [30:0] cfg_tol;
  logic [15:0] cfg_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_n   <= pgs_pkg::RST_INTERIOR;
      cfg_h   <= pgs_pkg::RST_SPACING;
      cfg_tol <= pgs_pkg::RST_TOL;
      cfg_max <= pgs_pkg::RST_SWEEPS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pgs_pkg::CFG_INTERIOR: cfg_n   <= cfg_data[3:0];
        pgs_pkg::CFG_SPACING:  cfg_h   <= cfg_data;
        pgs_pkg::CFG_TOL:      cfg_tol <= cfg_data;
        pgs_pkg::CFG_SWEEPS:   cfg_max <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers
  logic [2:0]         state;
  logic [2:0]         ph;
  logic [AW-1:0]      clr_cnt;
  logic [IW-1:0]      ci;
  logic [IW-1:0]      cj;
  logic [IW-1:0]      n_eff;
  logic [15:0]        k;
  logic [61:0]        hh;
  logic signed [31:0] src;
  logic signed [31:0] acc;
  logic signed [31:0] old_v;
  logic [30:0]        worst;
  logic [AW-1:0]      rd_lat;
  logic               rd_inside;
  logic [15:0]        res_count;
  logic               res_conv;
  logic [30:0]        res_change;

  // RAM ports
  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic [AW-1:0]      raddr;
  logic signed [31:0] rdata;

  pgs_grid_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Clamp interior count to the store
  assign n_eff = (int'(cfg_n) > NMAX) ? IW'(NMAX) : IW'(cfg_n);

  // Address decode
  logic          in_inside;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] c_addr;
  logic          in_acc;
  logic          out_free;

  assign in_inside = (int'(row) < GRID_SIDE) && (int'(col) < GRID_SIDE);
  assign in_addr   = AW'(int'(row) * GRID_SIDE + int'(col));
  assign c_addr    = AW'(int'(ci) * GRID_SIDE + int'(cj));
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Source term: (h*h + 2^14) >> 15, saturated
  logic [46:0] t2;
  assign t2 = 47'((hh + 62'h4000) >> 15);

  // New value and absolute change of the current cell
  logic signed [31:0] nv;
  logic signed [32:0] diff;
  logic [32:0]        absd;
  logic [30:0]        dsat;

  assign nv   = acc >>> 2;
  assign diff = {nv[31], nv} - {old_v[31], old_v};
  assign absd = diff[32] ? 33'(-diff) : 33'(diff);
  assign dsat = (absd > 33'(pgs_pkg::MAX_POS31)) ? pgs_pkg::MAX_POS31 : absd[30:0];

  // Read address select
  always_comb begin
    raddr = c_addr;
    unique case (state)
      S_IDLE: raddr = in_addr;
      S_READ: raddr = rd_lat;
      S_CELL: begin
        case (ph)
          PH_UP:    raddr = c_addr - AW'(GRID_SIDE);
          PH_DOWN:  raddr = c_addr + AW'(GRID_SIDE);
          PH_LEFT:  raddr = c_addr - AW'(1);
          PH_RIGHT: raddr = c_addr + AW'(1);
          default:  raddr = c_addr;
        endcase
      end
      default: raddr = c_addr;
    endcase
  end

  // Write port select
  always_comb begin
    we    = 1'b0;
    waddr = c_addr;
    wdata = nv;
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_cnt;
      wdata = '0;
    end else if (in_acc && func == pgs_pkg::FUNC_LOAD && in_inside) begin
      we    = 1'b1;
      waddr = in_addr;
      wdata = load_value;
    end else if (state == S_CELL && ph == PH_WRITE) begin
      we    = 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == S_SRC1) begin
      hh <= 62'(cfg_h) * 62'(cfg_h);
    end
    if (state == S_SRC2) begin
      src <= (t2 > 47'(pgs_pkg::MAX_POS31)) ? 32'sh7FFF_FFFF : signed'(t2[31:0]);
    end
    if (in_acc) begin
      rd_lat    <= in_addr;
      rd_inside <= in_inside;
    end
    if (state == S_CELL) begin
      case (ph)
        PH_DOWN:  acc <= rdata;
        PH_LEFT,
        PH_RIGHT,
        PH_OLD:   acc <= pgs_pkg::sat_add(acc, rdata);
        PH_SRC: begin
          old_v <= rdata;
          acc   <= pgs_pkg::sat_add(acc, src);
        end
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      ph      <= PH_UP;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            if (func == pgs_pkg::FUNC_READ) begin
              state <= S_READ;
            end else if (func == pgs_pkg::FUNC_SOLVE) begin
              state <= S_SRC1;
            end
          end
        end
        S_READ: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_SRC1: state <= S_SRC2;
        S_SRC2: begin
          worst <= '0;
          ci    <= IW'(1);
          cj    <= IW'(1);
          ph    <= PH_UP;
          k     <= 16'd1;
          if (cfg_max == 16'd0) begin
            res_count  <= '0;
            res_conv   <= 1'b0;
            res_change <= '0;
            state      <= S_DONE;
          end else if (n_eff == '0) begin
            state <= S_SWEND;
          end else begin
            state <= S_CELL;
          end
        end
        S_CELL: begin
          if (ph == PH_WRITE) begin
            ph <= PH_UP;
            if (dsat > worst) begin
              worst <= dsat;
            end
            if (cj == n_eff) begin
              cj <= IW'(1);
              if (ci == n_eff) begin
                state <= S_SWEND;
              end else begin
                ci <= ci + IW'(1);
              end
            end else begin
              cj <= cj + IW'(1);
            end
          end else begin
            ph <= ph + 3'd1;
          end
        end
        S_SWEND: begin
          res_count  <= k;
          res_change <= worst;
          res_conv   <= (worst < cfg_tol);
          if (worst < cfg_tol || k == cfg_max) begin
            state <= S_DONE;
          end else begin
            k     <= k + 16'd1;
            worst <= '0;
            ci    <= IW'(1);
            cj    <= IW'(1);
            state <= (n_eff == '0) ? S_SWEND : S_CELL;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free && (state == S_READ || state == S_DONE)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && state == S_READ) begin
      cell_value  <= rd_inside ? rdata : '0;
      sweep_count <= '0;
      converged   <= 1'b0;
      max_change  <= '0;
    end else if (out_free && state == S_DONE) begin
      cell_value  <= '0;
      sweep_count <= res_count;
      converged   <= res_conv;
      max_change  <= res_change;
    end
  end

  // Checks
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !in_ready)
    else $error("input accepted during clearing pass");

  a_cell_write_phase: assert property (@(posedge clk) disable iff (rst)
    (state == S_CELL && we) |-> ph == PH_WRITE)
    else $error("grid write outside write phase");

  a_conv_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && converged) |-> sweep_count != 16'd0)
    else $error("converged with zero sweeps");

  a_cell_bounds: assert property (@(posedge clk) disable iff (rst)
    state == S_CELL |-> (ci != '0 && cj != '0 && ci <= n_eff && cj <= n_eff))
    else $error("cell index outside interior");

endmodule

@@ tb/sv/poisson_gauss_seidel_solver_core_tb.sv @@
// ----------------------------------------------------------------------------
// poisson_gauss_seidel_solver_core_tb
// Self-checking bench for the Gauss-Seidel Poisson solver core. A scoreboard
// keeps its own grid and register copy, solves in step with every accepted
// transaction and compares each result field by field. Stimulus runs a
// directed set and then random load/solve/read traffic over several register
// settings, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module poisson_gauss_seidel_solver_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE = 16;

  // Function code with no meaning; the core must drop it
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef struct packed {
    logic signed [31:0] cell_val;
    logic [15:0]        cnt;
    logic               conv;
    logic [30:0]        chg;
  } gs_result_t;

  // Grid copy, register copy and the queue of pending results
  class gs_scoreboard;
    logic signed [31:0] grid [SIDE*SIDE];
    logic [3:0]  interior;
    logic [30:0] spacing;
    logic [30:0] tol;
    logic [15:0] sweep_limit;
    gs_result_t  pending_q [$];
    int errors, loads, reads, solves, sweeps_run;

    function void reset_state();
      foreach (grid[i]) grid[i] = '0;
      interior = pgs_pkg::RST_INTERIOR;
      spacing = pgs_pkg::RST_SPACING;
      tol = pgs_pkg::RST_TOL;
      sweep_limit = pgs_pkg::RST_SWEEPS;
    endfunction

    function void write_reg(logic [1:0] idx, logic [30:0] data);
      case (idx)
        pgs_pkg::CFG_INTERIOR: interior = data[3:0];
        pgs_pkg::CFG_SPACING:  spacing = data;
        pgs_pkg::CFG_TOL:      tol = data;
        pgs_pkg::CFG_SWEEPS:   sweep_limit = data[15:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Run the sweeps of one solve on the local grid
    function gs_result_t relax();
      gs_result_t r;
      longint unsigned hh, t2;
      longint src, s, nv, d, worst;
      int n, c;
      r = '0;
      hh = longint'(spacing) * longint'(spacing);
      t2 = (hh + 64'd16384) >> 15;
      src = (t2 > 64'd2147483647) ? 64'sd2147483647 : longint'(t2);
      n = (int'(interior) > SIDE - 2) ? SIDE - 2 : int'(interior);
      for (int k = 1; k <= sweep_limit; k++) begin
        worst = 0;
        for (int i = 1; i <= n; i++) begin
          for (int j = 1; j <= n; j++) begin
            c = i * SIDE + j;
            s = grid[c - SIDE];
            s = clamp32(s + grid[c + SIDE]);
            s = clamp32(s + grid[c - 1]);
            s = clamp32(s + grid[c + 1]);
            s = clamp32(s + src);
            nv = (s >= 0) ? s / 4 : -((-s + 3) / 4);
            d = nv - grid[c];
            if (d < 0) d = -d;
            if (d > worst) worst = d;
            grid[c] = nv[31:0];
          end
        end
        if (worst > 64'sd2147483647) worst = 64'sd2147483647;
        r.cnt = k[15:0];
        r.chg = worst[30:0];
        sweeps_run++;
        if (worst < longint'(tol)) begin
          r.conv = 1'b1;
          break;
        end
      end
      return r;
    endfunction

    // Note an accepted input transaction
    function void note_item(logic [1:0] f, logic [3:0] r, logic [3:0] c,
                            logic signed [31:0] v);
      gs_result_t res;
      res = '0;
      case (f)
        pgs_pkg::FUNC_LOAD: begin
          grid[{r, c}] = v;
          loads++;
        end
        pgs_pkg::FUNC_READ: begin
          res.cell_val = grid[{r, c}];
          pending_q.push_back(res);
          reads++;
        end
        pgs_pkg::FUNC_SOLVE: begin
          pending_q.push_back(relax());
          solves++;
        end
        default: ;
      endcase
    endfunction

    // Compare one result transaction with the oldest expectation
    function void check_result(gs_result_t got);
      gs_result_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result cell=%0d cnt=%0d conv=%0d chg=%0d",
                 $realtime, got.cell_val, got.cnt, got.conv, got.chg);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.cell_val !== exp_r.cell_val) begin
        $display("%0t: cell_value expected %0d actual %0d",
                 $realtime, exp_r.cell_val, got.cell_val);
        errors++;
      end
      if (got.cnt !== exp_r.cnt) begin
        $display("%0t: sweep_count expected %0d actual %0d", $realtime, exp_r.cnt, got.cnt);
        errors++;
      end
      if (got.conv !== exp_r.conv) begin
        $display("%0t: converged expected %0d actual %0d", $realtime, exp_r.conv, got.conv);
        errors++;
      end
      if (got.chg !== exp_r.chg) begin
        $display("%0t: max_change expected %0d actual %0d", $realtime, exp_r.chg, got.chg);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = pgs_pkg::CFG_INTERIOR;
  logic [30:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         func = pgs_pkg::FUNC_LOAD;
  logic [3:0]         row = '0;
  logic [3:0]         col = '0;
  logic signed [31:0] load_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] cell_value;
  logic [15:0]        sweep_count;
  logic               converged;
  logic [30:0]        max_change;

  gs_scoreboard sb = new();
  int burst_left = 0;
  int stall_mode = 0;
  int stall_cnt = 0;

  poisson_gauss_seidel_solver_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .row(row), .col(col),
    .load_value(load_value), .out_valid(out_valid), .out_ready(out_ready),
    .cell_value(cell_value), .sweep_count(sweep_count), .converged(converged),
    .max_change(max_change)
  );

  always #2 clk = ~clk;

  // Stall the output on a pattern re-chosen at random whenever the stall counter runs out
  always @(posedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_cnt <= 64;
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      0, 1: out_ready <= 1'b1;
      2: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{cell_value, sweep_count, converged, max_change});
  end

  // Drive one input transaction and hold it until accepted
  task automatic send(logic [1:0] f, logic [3:0] r, logic [3:0] c, logic signed [31:0] v);
    in_valid <= 1'b1;
    func <= f;
    row <= r;
    col <= c;
    load_value <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_item(f, r, c, v);
  endtask

  // Insert a random gap between bursts
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Drain all results, let any load finish, then write the registers
  task automatic set_regs(logic [3:0] n, logic [30:0] h, logic [30:0] t, logic [15:0] ms);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= pgs_pkg::CFG_INTERIOR;
    cfg_data <= {27'd0, n};
    @(posedge clk);
    cfg_index <= pgs_pkg::CFG_SPACING;
    cfg_data <= h;
    @(posedge clk);
    cfg_index <= pgs_pkg::CFG_TOL;
    cfg_data <= t;
    @(posedge clk);
    cfg_index <= pgs_pkg::CFG_SWEEPS;
    cfg_data <= {15'd0, ms};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(pgs_pkg::CFG_INTERIOR, {27'd0, n});
    sb.write_reg(pgs_pkg::CFG_SPACING, h);
    sb.write_reg(pgs_pkg::CFG_TOL, t);
    sb.write_reg(pgs_pkg::CFG_SWEEPS, {15'd0, ms});
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    endcase
  endfunction

  // Random traffic: mostly loads and reads, with solves in between
  task automatic run_random(int count);
    int p;
    for (int i = 0; i < count; i++) begin
      pace();
      p = $urandom_range(0, 99);
      if (p < 55)
        send(pgs_pkg::FUNC_LOAD, 4'($urandom()), 4'($urandom()), rand_value());
      else if (p < 85)
        send(pgs_pkg::FUNC_READ, 4'($urandom()), 4'($urandom()), $urandom());
      else if (p < 97)
        send(pgs_pkg::FUNC_SOLVE, 4'($urandom()), 4'($urandom()), $urandom());
      else
        send(FUNC_SPARE, 4'($urandom()), 4'($urandom()), $urandom());
    end
  endtask

  initial begin
    sb.reset_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes of cells and values, every function, unused code
    send(pgs_pkg::FUNC_LOAD, 4'd0, 4'd1, 32'sh7FFF_FFFF);
    send(pgs_pkg::FUNC_LOAD, 4'd0, 4'd2, 32'sh7FFF_FFFF);
    send(pgs_pkg::FUNC_LOAD, 4'd1, 4'd0, 32'sh8000_0000);
    send(pgs_pkg::FUNC_LOAD, 4'd4, 4'd2, 32'sh0001_0000);
    send(pgs_pkg::FUNC_LOAD, 4'd2, 4'd4, -32'sh0002_0000);
    send(pgs_pkg::FUNC_LOAD, 4'd15, 4'd15, 32'sh5A5A_A5A5);
    send(pgs_pkg::FUNC_LOAD, 4'd2, 4'd2, 32'sh1234_5678);
    send(FUNC_SPARE, 4'd15, 4'd15, 32'sh0);
    send(pgs_pkg::FUNC_READ, 4'd15, 4'd15, 32'sh0);
    send(pgs_pkg::FUNC_READ, 4'd0, 4'd0, 32'sh0);
    send(pgs_pkg::FUNC_SOLVE, 4'd0, 4'd0, 32'sh0);
    for (int i = 0; i < 5; i++) send(pgs_pkg::FUNC_READ, i[3:0], 4'd2, 32'sh0);
    send(pgs_pkg::FUNC_SOLVE, 4'd15, 4'd15, -32'sh1);
    send(pgs_pkg::FUNC_READ, 4'd1, 4'd1, 32'sh0);

    // Random phases over several register settings
    set_regs(4'd1, 31'd1, 31'd0, 16'd5);
    run_random(90);
    set_regs(4'd2, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd20);
    run_random(90);
    set_regs(4'd4, 31'd65536, 31'($urandom_range(0, 200)), 16'd30);
    run_random(120);
    set_regs(4'd14, 31'd32768, 31'd100, 16'd2);
    run_random(60);
    set_regs(4'd15, 31'($urandom()), 31'($urandom_range(0, 1000)), 16'd1);
    run_random(40);
    set_regs(4'd0, 31'd1000, 31'd0, 16'd65535);
    run_random(25);
    set_regs(4'd3, 31'd65536, 31'd7, 16'd0);
    run_random(80);
    set_regs(4'd3, 31'($urandom()), 31'($urandom_range(0, 5000)), 16'd16);
    run_random(150);
    set_regs(4'd2, 31'd4096, 31'd50, 16'd65535);
    run_random(120);
    set_regs(4'($urandom_range(1, 5)), 31'($urandom_range(1, 1 << 20)), 31'($urandom()),
             16'd12);
    run_random(80);

    // Drain and finish
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d loads, %0d reads, %0d solves (%0d sweeps)",
             sb.loads, sb.reads, sb.solves, sb.sweeps_run);
    $display("over 11 register settings");
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding", sb.pending_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
